/* src/cbf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the comment blanking filter.
// No dependencies; the files of the block but cbf_if refer to it by scoped names.
package cbf_pkg;

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_NL    = 8'h0A;

   // Most bytes one input item can cause.
   localparam int MaxResults = 4;
   localparam int CountW     = $clog2(MaxResults + 1);
   localparam int IdxW       = $clog2(MaxResults);

   // Default depth of the queue between the front and the back.
   localparam int QueueDepth = 2;

   // Block comment tracking in the first pass.
   typedef enum logic [2:0] {
      BLK_OUT  = 3'b001,   // outside a block comment
      BLK_IN   = 3'b010,   // inside, last byte not a star
      BLK_STAR = 3'b100    // inside, last byte a star
   } block_mode_type;

   // Bytes caused by one input item, in output order.
   typedef struct packed {
      logic [MaxResults-1:0][7:0] bytes;
      logic [CountW-1:0]          count;
      logic                       last;
   } group_type;

endpackage

/* src/cbf_if.sv */
`timescale 1ns / 1ps
// Valid/ready channels of the comment blanking filter: text in, filtered text out.
// No dependencies.
interface cbf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_end;

   modport source (output valid, output in_byte, output stream_end, input ready);
   modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface cbf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   logic       text_end;

   modport source (output valid, output out_byte, output run_end, output text_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_end, input text_end,
                   output ready);
endinterface

/* src/cbf_front.sv */
`timescale 1ns / 1ps
// Front of the filter: accepts text bytes, runs both blanking passes.
// Depends on cbf_pkg and cbf_if; queues one byte group per item causing bytes.
module cbf_front (
   input  logic                clock,
   input  logic                reset,
   cbf_req_if.sink             req,
   input  logic                push_ready,
   output logic                push_valid,
   output cbf_pkg::group_type  push_group
);

   typedef struct packed {
      logic                                        lm;
      logic                                        lh;
      logic [cbf_pkg::CountW-1:0]                  cnt;
      logic [cbf_pkg::MaxResults-1:0][7:0]         bytes;
   } work_type;

   cbf_pkg::block_mode_type block_mode_ff, block_mode_in;
   logic                    block_held_ff, block_held_in;
   logic                    line_mode_ff, line_mode_in;
   logic                    line_held_ff, line_held_in;
   work_type                w;
   logic                    opened;
   logic                    accept;

   // Append one byte; drop it beyond the group size.
   function automatic work_type emit(work_type a, logic [7:0] b);
      work_type r;
      r = a;
      if (r.cnt < cbf_pkg::CountW'(cbf_pkg::MaxResults)) begin
         r.bytes[r.cnt[cbf_pkg::IdxW-1:0]] = b;
         r.cnt = r.cnt + 1'b1;
      end
      return r;
   endfunction

   // Second pass: slash-slash comments, one byte from the first pass.
   function automatic work_type line_feed(work_type a, logic [7:0] c);
      work_type r;
      logic     done;
      r    = a;
      done = 1'b0;
      if (r.lm) begin
         r = emit(r, cbf_pkg::CH_NL);
         if (c == cbf_pkg::CH_NL) r.lm = 1'b0;
      end else begin
         if (r.lh) begin
            r.lh = 1'b0;
            if (c == cbf_pkg::CH_SLASH) begin
               r    = emit(r, cbf_pkg::CH_NL);
               r    = emit(r, cbf_pkg::CH_NL);
               r.lm = 1'b1;
               done = 1'b1;
            end else begin
               r = emit(r, cbf_pkg::CH_SLASH);
            end
         end
         if (!done) begin
            if (c == cbf_pkg::CH_SLASH) r.lh = 1'b1;
            else                        r = emit(r, c);
         end
      end
      return r;
   endfunction

   assign accept    = req.valid && req.ready;
   assign req.ready = push_ready;

   // First pass on the incoming byte, feeding the second pass.
   always_comb begin
      w             = '0;
      w.lm          = line_mode_ff;
      w.lh          = line_held_ff;
      block_mode_in = block_mode_ff;
      block_held_in = block_held_ff;
      opened        = 1'b0;
      if (block_mode_ff != cbf_pkg::BLK_OUT) begin
         w = line_feed(w, cbf_pkg::CH_NL);
         if (block_mode_ff == cbf_pkg::BLK_STAR && req.in_byte == cbf_pkg::CH_SLASH)
            block_mode_in = cbf_pkg::BLK_OUT;
         else if (req.in_byte == cbf_pkg::CH_STAR)
            block_mode_in = cbf_pkg::BLK_STAR;
         else
            block_mode_in = cbf_pkg::BLK_IN;
      end else begin
         if (block_held_ff) begin
            block_held_in = 1'b0;
            if (req.in_byte == cbf_pkg::CH_STAR) begin
               w             = line_feed(w, cbf_pkg::CH_NL);
               w             = line_feed(w, cbf_pkg::CH_NL);
               block_mode_in = cbf_pkg::BLK_STAR;
               opened        = 1'b1;
            end else begin
               w = line_feed(w, cbf_pkg::CH_SLASH);
            end
         end
         if (!opened) begin
            if (req.in_byte == cbf_pkg::CH_SLASH) block_held_in = 1'b1;
            else                                  w = line_feed(w, req.in_byte);
         end
      end
      // flush held slashes and drop open comments at stream end
      if (req.stream_end) begin
         if (block_held_in) begin
            block_held_in = 1'b0;
            w             = line_feed(w, cbf_pkg::CH_SLASH);
         end
         if (w.lh) begin
            w.lh = 1'b0;
            w    = emit(w, cbf_pkg::CH_SLASH);
         end
         block_mode_in = cbf_pkg::BLK_OUT;
         w.lm          = 1'b0;
      end
      line_mode_in = w.lm;
      line_held_in = w.lh;
   end

   assign push_valid       = accept && (w.cnt != '0);
   assign push_group.bytes = w.bytes;
   assign push_group.count = w.cnt;
   assign push_group.last  = req.stream_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_mode_ff <= cbf_pkg::BLK_OUT;
         block_held_ff <= 1'b0;
         line_mode_ff  <= 1'b0;
         line_held_ff  <= 1'b0;
      end else if (accept) begin
         block_mode_ff <= block_mode_in;
         block_held_ff <= block_held_in;
         line_mode_ff  <= line_mode_in;
         line_held_ff  <= line_held_in;
      end
   end

endmodule

/* src/cbf_queue.sv */
`timescale 1ns / 1ps
// Short queue of byte groups between the front and the back of the filter.
// Depends on cbf_pkg.
module cbf_queue #(
   parameter int Depth = cbf_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  cbf_pkg::group_type  push_group,
   output logic                push_ready,
   output logic                head_valid,
   output cbf_pkg::group_type  head_group,
   input  logic                pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cbf_pkg::group_type entry_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    fill_ff, fill_in;
   logic               do_push, do_pop;

   assign push_ready = (fill_ff != CntW'(Depth));
   assign head_valid = (fill_ff != '0);
   assign head_group = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      fill_in = fill_ff + 1'b1;
      else if (do_pop && !do_push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_group;
   end

endmodule

/* src/cbf_back.sv */
`timescale 1ns / 1ps
// Back of the filter: sends the bytes of each queued group, one per handshake.
// Depends on cbf_pkg and cbf_if.
module cbf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  cbf_pkg::group_type  head_group,
   output logic                pop,
   cbf_rsp_if.source           rsp
);

   logic [cbf_pkg::IdxW-1:0] idx_ff, idx_in;
   logic                     out_valid_ff, out_valid_in;
   logic [7:0]               out_byte_ff;
   logic                     run_end_ff;
   logic                     text_end_ff;
   logic                     load;
   logic                     group_done;

   // Load the output register when a group waits and it is empty or being taken.
   assign load       = head_valid && (!out_valid_ff || rsp.ready);
   assign group_done = ({1'b0, idx_ff} == (head_group.count - 1'b1));
   assign pop        = load && group_done;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (rsp.ready) out_valid_in = 1'b0;
      if (load) begin
         out_valid_in = 1'b1;
         idx_in       = group_done ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= head_group.bytes[idx_ff];
         run_end_ff  <= group_done;
         text_end_ff <= group_done && head_group.last;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.run_end  = run_end_ff;
   assign rsp.text_end = text_end_ff;

endmodule

/* src/comment_blanking_filter_unit.sv */
`timescale 1ns / 1ps
// Comment blanking filter: top level. Uses cbf_pkg, cbf_if, cbf_front,
// cbf_queue and cbf_back.
//
// Usage:
//   req_chan carries text bytes (in_byte) with stream_end on the last byte of
//   a text. rsp_chan returns the filtered bytes, with block comments and
//   slash-slash comments replaced by newline bytes. Each item causes zero to
//   four result bytes; run_end marks the last byte an item causes, text_end
//   the last byte of a whole text. Held slashes are flushed on stream_end and
//   all comment state starts fresh for the next text.
// Timing:
//   The front runs both passes on an item in the cycle it is accepted and
//   pushes any byte group it causes into a QueueDepth-entry queue. The back
//   drains one byte per cycle into an output register while rsp_chan is
//   ready; the first byte of an item passes the queue and then the output
//   register before it is offered on rsp_chan. Throughput is one item per
//   cycle while items cause one byte each and rsp_chan is ready; an item
//   of more bytes holds the single output port; the queue fills behind it.
// Reset and stalls:
//   Synchronous reset empties the queue and the output register and returns
//   both passes to outside any comment. When rsp_chan stalls, hold the output
//   byte; req_chan keeps accepting until the queue is full.
module comment_blanking_filter_unit #(
   parameter int QueueDepth = cbf_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   cbf_req_if.sink    req_chan,
   cbf_rsp_if.source  rsp_chan
);

   logic               push_valid;
   logic               push_ready;
   cbf_pkg::group_type push_group;
   logic               head_valid;
   cbf_pkg::group_type head_group;
   logic               pop;

   // Front: accept and classify, one group per item that causes bytes.
   cbf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_group (push_group)
   );

   // Decouple the two sides so each can stall on its own.
   cbf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_group (push_group),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_group (head_group),
      .pop        (pop)
   );

   // Back: serialize groups into single output bytes.
   cbf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_group (head_group),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

/* tb/sv/tb_comment_blanking_filter_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench of comment_blanking_filter_unit: directed and random text.
// Depends on cbf_pkg, cbf_if and the filter RTL; the predictor is self-contained.
module tb_comment_blanking_filter_unit;

   localparam int StallLimit  = 2000;  // cycles with no item moved on either side
   localparam int DrainCycles = 12;    // settle time once nothing is expected
   localparam int HoldCycles  = 64;    // long output hold-off

   // One byte of filtered text as it should leave the block.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       text_end;
   } filtered_byte_type;

   logic clock;
   logic reset;

   cbf_req_if req_chan ();
   cbf_rsp_if rsp_chan ();

   comment_blanking_filter_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state: mirror of both passes.
   cbf_pkg::block_mode_type blk_mode;
   logic                    blk_held;
   logic                    ln_mode;
   logic                    ln_held;
   logic [7:0]              group_bytes[$];      // bytes caused by the current item
   filtered_byte_type       expected_bytes[$];   // filtered bytes still owed by the block

   int  error_count;
   int  idle_cycles;
   bit  req_idle_en;
   bit  rsp_idle_en;
   bit  rsp_hold_req;

   // ---------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor of the two chained passes
   // ---------------------------------------------------------------------
   function automatic void push_out(logic [7:0] b);
      if (group_bytes.size() < cbf_pkg::MaxResults)
         group_bytes.insert(group_bytes.size(), b);
   endfunction

   // Second pass: slash-slash comments, blanked through the ending newline.
   function automatic void pass_line(logic [7:0] c);
      if (ln_mode) begin
         push_out(cbf_pkg::CH_NL);
         if (c == cbf_pkg::CH_NL) ln_mode = 1'b0;
         return;
      end
      if (ln_held) begin
         ln_held = 1'b0;
         if (c == cbf_pkg::CH_SLASH) begin
            push_out(cbf_pkg::CH_NL);
            push_out(cbf_pkg::CH_NL);
            ln_mode = 1'b1;
            return;
         end
         push_out(cbf_pkg::CH_SLASH);
      end
      if (c == cbf_pkg::CH_SLASH) ln_held = 1'b1;
      else push_out(c);
   endfunction

   // First pass: block comments; every byte it blanks feeds the second pass as a newline.
   function automatic void pass_block(logic [7:0] c);
      if (blk_mode != cbf_pkg::BLK_OUT) begin
         pass_line(cbf_pkg::CH_NL);
         if (blk_mode == cbf_pkg::BLK_STAR && c == cbf_pkg::CH_SLASH)
            blk_mode = cbf_pkg::BLK_OUT;
         else
            blk_mode = (c == cbf_pkg::CH_STAR) ? cbf_pkg::BLK_STAR : cbf_pkg::BLK_IN;
         return;
      end
      if (blk_held) begin
         blk_held = 1'b0;
         if (c == cbf_pkg::CH_STAR) begin
            pass_line(cbf_pkg::CH_NL);
            pass_line(cbf_pkg::CH_NL);
            // the opening star can also close the comment
            blk_mode = cbf_pkg::BLK_STAR;
            return;
         end
         pass_line(cbf_pkg::CH_SLASH);
      end
      if (c == cbf_pkg::CH_SLASH) blk_held = 1'b1;
      else pass_line(c);
   endfunction

   // Work out the filtered bytes of one accepted text byte and queue them.
   function automatic void blank_comments(logic [7:0] c, logic last);
      filtered_byte_type r;
      group_bytes.delete();
      pass_block(c);
      if (last) begin
         // flush the held slashes in pass order, then start a fresh text
         if (blk_held) begin
            blk_held = 1'b0;
            pass_line(cbf_pkg::CH_SLASH);
         end
         if (ln_held) begin
            ln_held = 1'b0;
            push_out(cbf_pkg::CH_SLASH);
         end
         blk_mode = cbf_pkg::BLK_OUT;
         ln_mode  = 1'b0;
      end
      foreach (group_bytes[k]) begin
         r.out_byte = group_bytes[k];
         r.run_end  = (k == group_bytes.size() - 1);
         r.text_end = r.run_end && last;
         expected_bytes.insert(expected_bytes.size(), r);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------
   // Offer one text byte; hold valid high afterwards so the next item can follow
   // back to back. Drop valid only for an idle burst.
   task automatic send_text_byte(input logic [7:0] b, input logic last);
      if (req_idle_en && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.in_byte    <= b;
      req_chan.stream_end <= last;
      do @(posedge clock); while (!req_chan.ready);
      blank_comments(b, last);
   endtask

   // Send a whole string as one text, stream_end on its last byte when asked.
   task automatic send_text(input string s, input bit ends);
      for (int i = 0; i < s.len(); i++)
         send_text_byte(s[i], ends && (i == s.len() - 1));
   endtask

   // Stop offering and wait until every expected byte has come out.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Bias toward the comment characters so that comments open and close often.
   function automatic logic [7:0] pick_text_byte();
      unique case ($urandom_range(0, 11))
         0, 1, 2: return cbf_pkg::CH_SLASH;
         3, 4:    return cbf_pkg::CH_STAR;
         5:       return cbf_pkg::CH_NL;
         6, 7:    return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   // Random texts of random length until about n_items bytes went in; the last
   // text is always completed.
   task automatic send_random_texts(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 14);
         for (int k = 0; k < len; k++)
            send_text_byte(pick_text_byte(), k == len - 1);
         sent += len;
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver side: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            // count the hold-off here so the sender keeps offering meanwhile
            rsp_chan.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            rsp_hold_req = 1'b0;
            rsp_chan.ready <= 1'b1;
         end else if (rsp_idle_en && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("ERROR @%0t: %s: got %02h, expected %02h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      filtered_byte_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("byte with nothing expected", rsp_chan.out_byte, 8'h00);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_chan.out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_chan.out_byte, want.out_byte);
            if (rsp_chan.run_end !== want.run_end)
               report_mismatch("run_end", 8'(rsp_chan.run_end), 8'(want.run_end));
            if (rsp_chan.text_end !== want.text_end)
               report_mismatch("text_end", 8'(rsp_chan.text_end), 8'(want.text_end));
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("Timeout: no item moved for %0d cycles", StallLimit);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Extreme byte values, then a comment closed by its own opening star and a
   // star right after the closing slash, which must pass through.
   task automatic test_extremes_and_short_close();
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'hFF, 1'b0);
      send_text("/*/*", 1'b1);
   endtask

   // Block comment, line comment ended by a newline, and a trailing slash that
   // both passes hold until the stream ends.
   task automatic test_mixed_comments();
      send_text("a/**/b//c\n/", 1'b1);
   endtask

   // Comments left open at the end of the stream.
   task automatic test_unterminated();
      send_text("/*x", 1'b1);
      send_text("//", 1'b1);
   endtask

   task automatic test_random_traffic();
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      send_random_texts(60);
   endtask

   // Hold the output off for a long stretch while text keeps coming, so the
   // queue fills and the input stalls; then let everything drain.
   task automatic test_output_backpressure();
      req_idle_en  = 1'b0;
      rsp_idle_en  = 1'b0;
      rsp_hold_req = 1'b1;
      send_text("x/*a*/y//zz\n", 1'b0);
      send_random_texts(20);
      wait_for_drain();
   endtask

   // Last part: no idling on either side.
   task automatic test_full_rate();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      send_random_texts(30);
   endtask

   initial begin
      error_count  = 0;
      req_idle_en  = 1'b0;
      rsp_idle_en  = 1'b0;
      rsp_hold_req = 1'b0;
      blk_mode     = cbf_pkg::BLK_OUT;
      blk_held     = 1'b0;
      ln_mode      = 1'b0;
      ln_held      = 1'b0;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.in_byte    <= 8'h00;
      req_chan.stream_end <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_extremes_and_short_close();
      test_mixed_comments();
      test_unterminated();
      test_random_traffic();
      test_output_backpressure();
      test_full_rate();
      wait_for_drain();

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
